// File: src/gdcr_pkg.sv
// Shared types and constants of the column raycaster.
// No dependencies; imported by every module of the block but gdcr_mul.
package gdcr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SCREEN_W   = 640;
    localparam int SCREEN_H   = 480;
    localparam int MAP_DIM    = 64;
    localparam int MAP_AW     = 6;
    localparam int DIV_W      = 40;
    localparam int DVS_W      = 24;
    localparam int WALK_LIMIT = 2 * (MAP_DIM + (1 << (22 - FRAC_BITS))) + 4;

    typedef logic [2:0] tile_t;
    localparam tile_t TILE_WALL   = 3'd1;
    localparam tile_t TILE_CLOSED = 3'd2;
    localparam tile_t TILE_VOID   = 3'd4;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_ROWS    = 3'd6;
    localparam logic [2:0] CFG_COLS    = 3'd7;

    localparam logic [31:0] SIDE_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] SIDE_CAP = 32'hFFFF_FFFE;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

endpackage

// File: src/grid_dda_column_raycaster.sv
// Tile-map column raycaster: top level with sequencer, config and result register.
// Depends on gdcr_pkg, gdcr_div, gdcr_mul and gdcr_tile_map.
//
// Usage: an input word with s_action low writes one map cell (no result). A word
// with s_action high casts the ray of s_screen_column and
// yields one result word on the m_ channel. Configuration goes through the plain
// write port cfg_we/cfg_index/cfg_data while the block is idle.
// A cast runs through one shared divider (two reciprocals, perpendicular distance,
// line height), one registered multiplier (camera by reciprocal, two ray
// components, two first side distances) and a DDA walk of up to 260 cells.
// A zero ray component skips its reciprocal and side multiply.
// The block takes one cast at a time and s_ready stays low during it.
// After reset a clearing pass writes void into all 4096 map cells, one a cycle;
// s_ready stays low until the pass ends.
// A finished result sits in the output register until taken; while the receiver
// stalls the block can still accept the next word, and holds a further finished
// result back until the output register frees.
module grid_dda_column_raycaster (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [5:0]         s_cell_col,
    input  logic [5:0]         s_cell_row,
    input  logic [2:0]         s_tile_code,
    input  logic [9:0]         s_screen_column,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_column_out,
    output logic signed [7:0]  m_hit_col,
    output logic signed [7:0]  m_hit_row,
    output logic               m_hit_side,
    output logic [1:0]         m_wall_face,
    output logic               m_hit_is_door,
    output logic               m_hit_outside,
    output logic [23:0]        m_perp_distance,
    output logic [15:0]        m_line_height,
    output logic [8:0]         m_draw_start,
    output logic [8:0]         m_draw_end
);
    import gdcr_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CAM, ST_RAYX, ST_RAYY, ST_DLX, ST_DLY,
        ST_SDX, ST_SDY, ST_STEP, ST_PROBE, ST_PERP, ST_LH, ST_OUT
    } state_t;

    localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << (2 * FRAC_BITS);
    localparam logic [DIV_W-1:0] LH_NUM    = DIV_W'(SCREEN_H) << FRAC_BITS;
    localparam logic [8:0]       HALF_H    = 9'(SCREEN_H / 2);
    localparam logic [8:0]       LAST_ROW  = 9'(SCREEN_H - 1);
    localparam logic [1:0]       FACE_N = 2'd0, FACE_S = 2'd1, FACE_W = 2'd2, FACE_E = 2'd3;
    // ceil(2^30 / SCREEN_W): col * CAM_RECIP >> 13 gives floor(col * 2^17 / SCREEN_W)
    // exactly for every 10-bit column
    localparam logic signed [33:0] CAM_RECIP =
        34'(((longint'(1) << 30) + SCREEN_W - 1) / SCREEN_W);

    // configuration registers
    logic [21:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [6:0]         rows_reg, cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= 22'd2129920;
            pos_y_reg   <= 22'd2129920;
            dir_x_reg   <= 18'sd0;
            dir_y_reg   <= -18'sd65536;
            plane_x_reg <= 18'sd43254;
            plane_y_reg <= 18'sd0;
            rows_reg    <= 7'd64;
            cols_reg    <= 7'd64;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POS_X:   pos_x_reg   <= cfg_data;
                CFG_POS_Y:   pos_y_reg   <= cfg_data;
                CFG_DIR_X:   dir_x_reg   <= cfg_data[17:0];
                CFG_DIR_Y:   dir_y_reg   <= cfg_data[17:0];
                CFG_PLANE_X: plane_x_reg <= cfg_data[17:0];
                CFG_PLANE_Y: plane_y_reg <= cfg_data[17:0];
                CFG_ROWS:    rows_reg    <= cfg_data[6:0];
                CFG_COLS:    cols_reg    <= cfg_data[6:0];
                default:     rows_reg    <= rows_reg;
            endcase
        end
    end

    // sequencer state
    state_t             state_reg, state_next;
    logic               ph_reg, ph_next;
    logic [11:0]        clr_reg, clr_next;
    logic [9:0]         col_reg, col_next;
    logic signed [18:0] cam_reg, cam_next;
    logic signed [21:0] rdx_reg, rdx_next, rdy_reg, rdy_next;
    logic [31:0]        ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [31:0]        sx_reg, sx_next, sy_reg, sy_next;
    logic               infx_reg, infx_next, infy_reg, infy_next;
    logic signed [7:0]  wcol_reg, wcol_next, wrow_reg, wrow_next;
    logic               side_reg, side_next, door_reg, door_next, outs_reg, outs_next;
    logic [8:0]         n_reg, n_next;
    logic [23:0]        perp_reg, perp_next;
    logic [15:0]        lh_reg, lh_next;
    logic               m_valid_reg, m_valid_next;
    logic               load_out;

    // output register
    logic [9:0]         o_col_reg;
    logic signed [7:0]  o_hcol_reg, o_hrow_reg;
    logic               o_side_reg, o_door_reg, o_outs_reg;
    logic [1:0]         o_face_reg;
    logic [23:0]        o_perp_reg;
    logic [15:0]        o_lh_reg;
    logic [8:0]         o_ds_reg, o_de_reg;

    // shared units
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic signed [19:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [53:0] mul_p;
    logic               mem_we;
    logic [11:0]        mem_waddr, mem_raddr;
    tile_t              mem_wdata, mem_rdata;

    gdcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    gdcr_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    gdcr_tile_map u_map (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // combinational helpers
    logic [20:0]        abs_rdx, abs_rdy, abs_rd;
    logic [21:0]        neg_rdx, neg_rdy;
    logic [16:0]        frac_x, frac_y;
    logic [6:0]         rows_eff, cols_eff;
    logic [32:0]        sum_x, sum_y;
    logic [31:0]        cap_x, cap_y;
    logic signed [7:0]  ncol, nrow, cell_sel;
    logic               nout;
    logic signed [21:0] rd_sel;
    logic [21:0]        pos_sel;
    logic signed [25:0] num, neg_num;
    logic [23:0]        abs_num;
    logic               inf_sel;
    logic               s_fire;
    logic [1:0]         face;
    logic [8:0]         ds, de;

    always_comb begin
        neg_rdx  = -rdx_reg;
        neg_rdy  = -rdy_reg;
        abs_rdx  = rdx_reg[21] ? neg_rdx[20:0] : rdx_reg[20:0];
        abs_rdy  = rdy_reg[21] ? neg_rdy[20:0] : rdy_reg[20:0];
        // distance to the first grid line along each axis
        frac_x   = rdx_reg[21] ? {1'b0, pos_x_reg[15:0]}
                               : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        frac_y   = rdy_reg[21] ? {1'b0, pos_y_reg[15:0]}
                               : 17'h10000 - {1'b0, pos_y_reg[15:0]};
        rows_eff = (rows_reg > 7'(MAP_DIM)) ? 7'(MAP_DIM) : rows_reg;
        cols_eff = (cols_reg > 7'(MAP_DIM)) ? 7'(MAP_DIM) : cols_reg;
        cap_x    = infx_reg ? SIDE_INF : SIDE_CAP;
        cap_y    = infy_reg ? SIDE_INF : SIDE_CAP;
        sum_x    = {1'b0, sx_reg} + {1'b0, ddx_reg};
        sum_y    = {1'b0, sy_reg} + {1'b0, ddy_reg};
        // candidate cell of the next DDA step
        ncol = wcol_reg;
        nrow = wrow_reg;
        if (sx_reg < sy_reg) begin
            ncol = rdx_reg[21] ? wcol_reg - 8'sd1 : wcol_reg + 8'sd1;
        end else begin
            nrow = rdy_reg[21] ? wrow_reg - 8'sd1 : wrow_reg + 8'sd1;
        end
        nout = ncol[7] || (ncol[6:0] >= cols_eff) || nrow[7] || (nrow[6:0] >= rows_eff);
        // perpendicular distance operands of the crossed axis
        cell_sel = side_reg ? wrow_reg : wcol_reg;
        rd_sel   = side_reg ? rdy_reg : rdx_reg;
        pos_sel  = side_reg ? pos_y_reg : pos_x_reg;
        inf_sel  = side_reg ? infy_reg : infx_reg;
        abs_rd   = side_reg ? abs_rdy : abs_rdx;
        num      = {{2{cell_sel[7]}}, cell_sel, 16'h0000}
                 + (rd_sel[21] ? 26'sd65536 : 26'sd0)
                 - $signed({4'b0000, pos_sel});
        neg_num  = -num;
        abs_num  = num[25] ? neg_num[23:0] : num[23:0];
        // wall face and draw span
        if (side_reg) begin
            face = rdy_reg[21] ? FACE_N : FACE_S;
        end else begin
            face = rdx_reg[21] ? FACE_W : FACE_E;
        end
        if (lh_reg[15:1] >= 15'(HALF_H)) begin
            ds = 9'd0;
            de = LAST_ROW;
        end else begin
            ds = HALF_H - lh_reg[9:1];
            de = HALF_H + lh_reg[9:1];
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // map write port: clearing pass or cell write; read port follows the walk
    always_comb begin
        mem_we    = (state_reg == ST_CLEAR) || (s_fire && !s_action);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : {s_cell_row, s_cell_col};
        mem_wdata = (state_reg == ST_CLEAR) ? TILE_VOID : s_tile_code;
        mem_raddr = {nrow[5:0], ncol[5:0]};
    end

    // multiplier operands, held for both phases of a multiply state
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CAM: begin
                mul_a = $signed({10'd0, col_reg});
                mul_b = CAM_RECIP;
            end
            ST_RAYX: begin
                mul_a = 20'(plane_x_reg);
                mul_b = 34'(cam_reg);
            end
            ST_RAYY: begin
                mul_a = 20'(plane_y_reg);
                mul_b = 34'(cam_reg);
            end
            ST_SDX: begin
                mul_a = $signed({3'b000, frac_x});
                mul_b = $signed({2'b00, ddx_reg});
            end
            ST_SDY: begin
                mul_a = $signed({3'b000, frac_y});
                mul_b = $signed({2'b00, ddy_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        clr_next     = clr_reg;
        col_next     = col_reg;
        cam_next     = cam_reg;
        rdx_next     = rdx_reg;
        rdy_next     = rdy_reg;
        ddx_next     = ddx_reg;
        ddy_next     = ddy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        infx_next    = infx_reg;
        infy_next    = infy_reg;
        wcol_next    = wcol_reg;
        wrow_next    = wrow_reg;
        side_next    = side_reg;
        door_next    = door_reg;
        outs_next    = outs_reg;
        n_next       = n_reg;
        perp_next    = perp_reg;
        lh_next      = lh_reg;
        load_out     = 1'b0;
        div_req      = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 12'd1;
                if (clr_reg == 12'hFFF) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire && s_action) begin
                    col_next   = s_screen_column;
                    wcol_next  = {2'b00, pos_x_reg[21:16]};
                    wrow_next  = {2'b00, pos_y_reg[21:16]};
                    side_next  = 1'b0;
                    door_next  = 1'b0;
                    outs_next  = 1'b0;
                    n_next     = '0;
                    ph_next    = 1'b0;
                    state_next = ST_CAM;
                end
            end
            ST_CAM: begin
                // camera offset from the column by reciprocal multiplication
                ph_next = !ph_reg;
                if (ph_reg) begin
                    cam_next   = $signed({1'b0, mul_p[30:13]}) - 19'sd65536;
                    state_next = ST_RAYX;
                end
            end
            ST_RAYX: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    rdx_next   = 22'(dir_x_reg) + mul_p[37:16];
                    state_next = ST_RAYY;
                end
            end
            ST_RAYY: begin
                ph_next = !ph_reg;
                if (ph_reg) begin
                    rdy_next   = 22'(dir_y_reg) + mul_p[37:16];
                    state_next = ST_DLX;
                end
            end
            ST_DLX: begin
                if (rdx_reg == 22'sd0) begin
                    ddx_next   = SIDE_INF;
                    sx_next    = SIDE_INF;
                    infx_next  = 1'b1;
                    state_next = ST_DLY;
                end else if (!ph_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = RECIP_NUM;
                    div_req.divisor  = {3'b000, abs_rdx};
                    ph_next          = 1'b1;
                end else if (div_done) begin
                    ddx_next   = (div_q > DIV_W'(SIDE_CAP)) ? SIDE_CAP : div_q[31:0];
                    infx_next  = 1'b0;
                    ph_next    = 1'b0;
                    state_next = ST_DLY;
                end
            end
            ST_DLY: begin
                if (rdy_reg == 22'sd0) begin
                    ddy_next   = SIDE_INF;
                    sy_next    = SIDE_INF;
                    infy_next  = 1'b1;
                    state_next = ST_SDX;
                end else if (!ph_reg) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = RECIP_NUM;
                    div_req.divisor  = {3'b000, abs_rdy};
                    ph_next          = 1'b1;
                end else if (div_done) begin
                    ddy_next   = (div_q > DIV_W'(SIDE_CAP)) ? SIDE_CAP : div_q[31:0];
                    infy_next  = 1'b0;
                    ph_next    = 1'b0;
                    state_next = ST_SDX;
                end
            end
            ST_SDX: begin
                if (infx_reg) begin
                    state_next = ST_SDY;
                end else begin
                    ph_next = !ph_reg;
                    if (ph_reg) begin
                        sx_next    = (mul_p[48:16] > 33'(SIDE_CAP)) ? SIDE_CAP : mul_p[47:16];
                        state_next = ST_SDY;
                    end
                end
            end
            ST_SDY: begin
                if (infy_reg) begin
                    state_next = ST_STEP;
                end else begin
                    ph_next = !ph_reg;
                    if (ph_reg) begin
                        sy_next    = (mul_p[48:16] > 33'(SIDE_CAP)) ? SIDE_CAP : mul_p[47:16];
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (n_reg >= 9'(WALK_LIMIT)) begin
                    outs_next  = 1'b1;
                    state_next = ST_PERP;
                end else begin
                    n_next    = n_reg + 9'd1;
                    wcol_next = ncol;
                    wrow_next = nrow;
                    if (sx_reg < sy_reg) begin
                        sx_next   = (sum_x > {1'b0, cap_x}) ? cap_x : sum_x[31:0];
                        side_next = 1'b0;
                    end else begin
                        sy_next   = (sum_y > {1'b0, cap_y}) ? cap_y : sum_y[31:0];
                        side_next = 1'b1;
                    end
                    if (nout) begin
                        outs_next  = 1'b1;
                        state_next = ST_PERP;
                    end else begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                priority if (mem_rdata == TILE_VOID) begin
                    outs_next  = 1'b1;
                    state_next = ST_PERP;
                end else if (mem_rdata == TILE_WALL) begin
                    state_next = ST_PERP;
                end else if (mem_rdata == TILE_CLOSED) begin
                    door_next  = 1'b1;
                    state_next = ST_PERP;
                end else begin
                    state_next = ST_STEP;
                end
            end
            ST_PERP: begin
                if (!ph_reg) begin
                    if (inf_sel) begin
                        perp_next  = 24'hFF_FFFF;
                        state_next = ST_LH;
                    end else if (num == 26'sd0 || num[25] != rd_sel[21]) begin
                        // quotient truncates to zero or is negative: clamp to zero
                        perp_next  = 24'd0;
                        state_next = ST_LH;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {abs_num, 16'h0000};
                        div_req.divisor  = {3'b000, abs_rd};
                        ph_next          = 1'b1;
                    end
                end else if (div_done) begin
                    perp_next  = (div_q > 40'hFF_FFFF) ? 24'hFF_FFFF : div_q[23:0];
                    ph_next    = 1'b0;
                    state_next = ST_LH;
                end
            end
            ST_LH: begin
                if (!ph_reg) begin
                    if (perp_reg == 24'd0) begin
                        lh_next    = 16'hFFFF;
                        state_next = ST_OUT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = LH_NUM;
                        div_req.divisor  = perp_reg;
                        ph_next          = 1'b1;
                    end
                end else if (div_done) begin
                    lh_next    = (div_q > 40'hFFFF) ? 16'hFFFF : div_q[15:0];
                    ph_next    = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            ph_reg      <= 1'b0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            wcol_reg    <= '0;
            wrow_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            wcol_reg    <= wcol_next;
            wrow_reg    <= wrow_next;
        end
    end

    // working payload and result word
    always_ff @(posedge aclk) begin
        col_reg  <= col_next;
        cam_reg  <= cam_next;
        rdx_reg  <= rdx_next;
        rdy_reg  <= rdy_next;
        ddx_reg  <= ddx_next;
        ddy_reg  <= ddy_next;
        infx_reg <= infx_next;
        infy_reg <= infy_next;
        side_reg <= side_next;
        door_reg <= door_next;
        outs_reg <= outs_next;
        n_reg    <= n_next;
        perp_reg <= perp_next;
        lh_reg   <= lh_next;
        if (load_out) begin
            o_col_reg  <= col_reg;
            o_hcol_reg <= wcol_reg;
            o_hrow_reg <= wrow_reg;
            o_side_reg <= side_reg;
            o_face_reg <= face;
            o_door_reg <= door_reg;
            o_outs_reg <= outs_reg;
            o_perp_reg <= perp_reg;
            o_lh_reg   <= lh_reg;
            o_ds_reg   <= ds;
            o_de_reg   <= de;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_column_out    = o_col_reg;
    assign m_hit_col       = o_hcol_reg;
    assign m_hit_row       = o_hrow_reg;
    assign m_hit_side      = o_side_reg;
    assign m_wall_face     = o_face_reg;
    assign m_hit_is_door   = o_door_reg;
    assign m_hit_outside   = o_outs_reg;
    assign m_perp_distance = o_perp_reg;
    assign m_line_height   = o_lh_reg;
    assign m_draw_start    = o_ds_reg;
    assign m_draw_end      = o_de_reg;

endmodule

// File: src/gdcr_div.sv
// Restoring divider, one quotient bit per cycle, DIV_W quotient bits per division.
// Depends on gdcr_pkg for widths and the request struct.
module gdcr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gdcr_pkg::div_req_t            req,
    output logic                          done,
    output logic [gdcr_pkg::DIV_W-1:0]    quotient
);
    import gdcr_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W:0]     trial;
    logic [DVS_W:0]     diff;
    logic               ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/gdcr_mul.sv
// Registered signed multiplier shared by the ray and side-distance setup.
// Depends on nothing beyond its ports.
module gdcr_mul (
    input  logic               aclk,
    input  logic signed [19:0] a,
    input  logic signed [33:0] b,
    output logic signed [53:0] p
);
    logic signed [53:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: src/gdcr_tile_map.sv
// Tile map memory: one write port, one read port with registered data.
// Depends on gdcr_pkg for the tile type and address width.
module gdcr_tile_map (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [2*gdcr_pkg::MAP_AW-1:0] wr_addr,
    input  gdcr_pkg::tile_t               wr_data,
    input  logic [2*gdcr_pkg::MAP_AW-1:0] rd_addr,
    output gdcr_pkg::tile_t               rd_data
);
    import gdcr_pkg::*;

    tile_t mem [MAP_DIM*MAP_DIM];
    tile_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule
